// ----- sv/lwat_pkg.sv -----
// Shared types and constants for the windowed access load tracker.
// Depends on nothing; every other file imports it.
package lwat_pkg;

  localparam int CNT_W   = 32;
  localparam int LOAD_W  = 38;
  localparam int ALPHA_W = 9;
  localparam int EIU_W   = 7;
  localparam int SLOT_W  = 4;
  localparam int SUM_W   = CNT_W + SLOT_W;
  localparam int P1_W    = ALPHA_W + SUM_W;
  localparam int P2_W    = ALPHA_W + CNT_W;
  localparam int NUM_W   = P1_W + 1;
  localparam int DVD_W   = NUM_W - 8;

  typedef logic [2:0] opcode_t;
  localparam opcode_t OP_COUNT   = 3'd0;
  localparam opcode_t OP_END     = 3'd1;
  localparam opcode_t OP_CLEAR   = 3'd2;
  localparam opcode_t OP_COMPUTE = 3'd3;
  localparam opcode_t OP_READ    = 3'd4;

  localparam logic CFG_ENTRIES = 1'b0;
  localparam logic CFG_ALPHA   = 1'b1;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

  typedef struct packed {
    logic [CNT_W-1:0]  score;
    logic [SLOT_W-1:0] fill;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  count;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_FIN, S_FINRD, S_RESP,
    S_E_RD, S_E_WR,
    S_C_RD, S_C_LD, S_C_SUM, S_C_MUL, S_C_NUM, S_C_DIV, S_C_WR
  } state_t;

endpackage

// ----- sv/lwat_entry_mem.sv -----
// Per-entry state memory: count, ring fill, ring slot and score.
// Depends on lwat_pkg. Valid bits make unwritten or cleared entries read as zero.
module lwat_entry_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [AW-1:0]   rd_addr,
  output lwat_pkg::entry_t rd_data,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  lwat_pkg::entry_t wr_data,
  input  logic            clr_en,
  input  logic [AW-1:0]   clr_addr
);
  import lwat_pkg::*;

  entry_t           mem [DEPTH];
  entry_t           q_r;
  logic             vq_r;
  logic [DEPTH-1:0] valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      vq_r    <= 1'b0;
    end else begin
      vq_r <= valid_r[rd_addr];
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (clr_en) begin
        valid_r[clr_addr] <= 1'b0;
      end
    end
  end

  assign rd_data = vq_r ? q_r : '0;

endmodule

// ----- sv/lwat_ring_mem.sv -----
// History ring memory, one row of slots per entry, registered read.
// Depends on lwat_pkg. Only slots below an entry's fill are summed.
module lwat_ring_mem #(
  parameter int DEPTH = 768,
  parameter int AW    = 10
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [lwat_pkg::CNT_W-1:0] wr_data,
  input  logic [AW-1:0]              rd_addr,
  output logic [lwat_pkg::CNT_W-1:0] rd_data
);
  import lwat_pkg::*;

  logic [CNT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- sv/lwat_div.sv -----
// Restoring divider, one quotient bit per cycle, by a 4-bit divisor.
// Depends on lwat_pkg. Quotient keeps the low 32 bits.
module lwat_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [lwat_pkg::DVD_W-1:0]  dividend,
  input  logic [lwat_pkg::SLOT_W-1:0] divisor,
  output logic                        done,
  output logic [lwat_pkg::CNT_W-1:0]  quotient
);
  import lwat_pkg::*;

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic              busy_r;
  logic [STEP_W-1:0] step_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [SLOT_W-1:0] dsr_r;
  logic [SLOT_W:0]   rem_r;
  logic [CNT_W-1:0]  quo_r;
  logic              done_r;
  logic [SLOT_W+1:0] trial;
  logic              take;

  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign take  = trial >= {2'b00, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r <= take ? (SLOT_W+1)'(trial - {2'b00, dsr_r}) : trial[SLOT_W:0];
      quo_r <= {quo_r[CNT_W-2:0], take};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- sv/windowed_access_load_tracker.sv -----
// Top level of the windowed access load tracker: control sequencer around
// the entry memory, the history ring memory and the divider (lwat_pkg).
//
//  channel  | dir | word fields (low bit first)
//  ---------+-----+---------------------------------------------------------
//  in_      | in  | opcode[2:0], entry_index[8:3], zero fill to 16 bits
//  out_     | out | entry_score[31:0], load_level[69:32], status[70], zero
//  cfg_     | in  | index 0 entries_in_use (7b), index 1 alpha_q8 (9b)
//
// Count, clear and read words go through accept, memory read and result.
// End interval: per active entry a read and a write back, then the result.
// Compute: per active entry an entry read, a ring sum of one slot a cycle,
// weighting, a divide of one bit a step when fill is nonzero, write back.
// One word is worked at a time; in_tready is high only while idle, so it is
// low while a word runs or while its result waits for the output register.
// Reset is synchronous and clears the valid bits, so every entry reads as
// zero after reset.
module windowed_access_load_tracker #(
  parameter int MAX_ENTRIES = 64,
  parameter int WINDOW      = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // opcode[2:0], entry_index[8:3]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // entry_score[31:0], load_level[69:32], status[70]
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_wdata
);
  import lwat_pkg::*;

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW    = IDX_W + 8;
  localparam int RDEP  = MAX_ENTRIES * WINDOW;
  localparam int RA_W  = (RDEP > 1) ? $clog2(RDEP) : 1;

  // configuration
  logic [EIU_W-1:0]   eiu_r;
  logic [ALPHA_W-1:0] alpha_r;

  // word under work
  state_t             state_r, state_nxt;
  opcode_t            op_r, op_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               ok_r, ok_nxt;
  logic [CW-1:0]      n_r, n_nxt;
  logic [ALPHA_W-1:0] a_r, a_nxt;
  logic [CW-1:0]      e_r, e_nxt;
  entry_t             ent_r, ent_nxt;
  logic [SLOT_W-1:0]  k_r, k_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [P1_W-1:0]    p1_r, p1_nxt;
  logic [P2_W-1:0]    p2_r, p2_nxt;
  logic [LOAD_W-1:0]  load_r, load_nxt;
  logic [CNT_W-1:0]   score_r, score_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [71:0]        out_data_r, out_data_nxt;

  // memory and divider hookup
  logic [IDX_W-1:0]   ent_rd_addr, ent_wr_addr, e_idx;
  entry_t             ent_rd, ent_wr_data;
  logic               ent_wr_en, clr_en;
  logic               ring_wr_en;
  logic [RA_W-1:0]    ring_wr_addr, ring_rd_addr, ring_base;
  logic [CNT_W-1:0]   ring_q;
  logic               div_start, div_done;
  logic [DVD_W-1:0]   div_dvd;
  logic [CNT_W-1:0]   div_quo;

  // input decode
  opcode_t            in_op;
  logic [IDX_W-1:0]   in_idx;
  logic [IDX_W+5:0]   in_idx_ext;
  logic [CW-1:0]      n_cur, eiu_ext;
  logic               in_ok;
  logic [NUM_W-1:0]   num;
  logic [SLOT_W-1:0]  slot_inc;

  assign in_op      = in_tdata[2:0];
  assign in_idx_ext = {{IDX_W{1'b0}}, in_tdata[8:3]};
  assign in_idx     = in_idx_ext[IDX_W-1:0];
  assign eiu_ext    = CW'(eiu_r);
  assign n_cur      = (eiu_ext > CW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : eiu_ext;
  assign in_ok      = CW'(in_tdata[8:3]) < n_cur;
  assign e_idx      = e_r[IDX_W-1:0];
  assign ring_base  = RA_W'(e_idx) * RA_W'(WINDOW);
  assign num        = NUM_W'(p1_r) + NUM_W'(p2_r) * NUM_W'(ent_r.fill);
  assign slot_inc   = (ent_rd.slot == SLOT_W'(WINDOW - 1)) ? '0 : ent_rd.slot + 1'b1;
  assign div_dvd    = num[NUM_W-1:8];

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  lwat_entry_mem #(.DEPTH(MAX_ENTRIES), .AW(IDX_W)) u_entry (
    .clk, .rst_n,
    .rd_addr (ent_rd_addr), .rd_data (ent_rd),
    .wr_en   (ent_wr_en),   .wr_addr (ent_wr_addr), .wr_data (ent_wr_data),
    .clr_en  (clr_en),      .clr_addr (in_idx)
  );

  lwat_ring_mem #(.DEPTH(RDEP), .AW(RA_W)) u_ring (
    .clk,
    .wr_en (ring_wr_en), .wr_addr (ring_wr_addr), .wr_data (ent_rd.count),
    .rd_addr (ring_rd_addr), .rd_data (ring_q)
  );

  lwat_div u_div (
    .clk, .rst_n, .start (div_start), .dividend (div_dvd),
    .divisor (ent_r.fill), .done (div_done), .quotient (div_quo)
  );

  // configuration writes; the host issues them only while idle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eiu_r   <= 7'd64;
      alpha_r <= 9'd128;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENTRIES: eiu_r   <= cfg_wdata[EIU_W-1:0];
        CFG_ALPHA:   alpha_r <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      load_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      load_r      <= load_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    idx_r      <= idx_nxt;
    ok_r       <= ok_nxt;
    n_r        <= n_nxt;
    a_r        <= a_nxt;
    e_r        <= e_nxt;
    ent_r      <= ent_nxt;
    k_r        <= k_nxt;
    sum_r      <= sum_nxt;
    p1_r       <= p1_nxt;
    p2_r       <= p2_nxt;
    score_r    <= score_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    idx_nxt       = idx_r;
    ok_nxt        = ok_r;
    n_nxt         = n_r;
    a_nxt         = a_r;
    e_nxt         = e_r;
    ent_nxt       = ent_r;
    k_nxt         = k_r;
    sum_nxt       = sum_r;
    p1_nxt        = p1_r;
    p2_nxt        = p2_r;
    load_nxt      = load_r;
    score_nxt     = score_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ent_rd_addr   = idx_r;
    ent_wr_en     = 1'b0;
    ent_wr_addr   = e_idx;
    ent_wr_data   = ent_rd;
    clr_en        = 1'b0;
    ring_wr_en    = 1'b0;
    ring_wr_addr  = ring_base + RA_W'(ent_rd.slot);
    ring_rd_addr  = ring_base + RA_W'(k_r);
    div_start     = 1'b0;

    // drop the result once the sink takes it
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        ent_rd_addr = in_idx;
        if (in_tvalid) begin
          op_nxt  = in_op;
          idx_nxt = in_idx;
          ok_nxt  = in_ok;
          n_nxt   = n_cur;
          a_nxt   = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;
          e_nxt   = '0;
          clr_en  = (in_op == OP_CLEAR) && in_ok;
          if (in_op == OP_COMPUTE) begin
            load_nxt = '0;
          end
          if (in_op == OP_END && n_cur != '0) begin
            state_nxt = S_E_RD;
          end else if (in_op == OP_COMPUTE && n_cur != '0) begin
            state_nxt = S_C_RD;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_FINRD: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // cleared entry still shows old data this cycle: force zero
        score_nxt = (ok_r && op_r != OP_CLEAR) ? ent_rd.score : '0;
        if (op_r == OP_COUNT && ok_r) begin
          ent_wr_en         = 1'b1;
          ent_wr_addr       = idx_r;
          ent_wr_data.count = ent_rd.count + 1'b1;
        end
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, !ok_r, load_r, score_r};
          state_nxt     = S_IDLE;
        end
      end
      // end interval: push count into ring, advance slot, grow fill, zero count
      S_E_RD: begin
        ent_rd_addr = e_idx;
        state_nxt   = S_E_WR;
      end
      S_E_WR: begin
        ring_wr_en        = 1'b1;
        ent_wr_en         = 1'b1;
        ent_wr_data.count = '0;
        ent_wr_data.slot  = slot_inc;
        ent_wr_data.fill  = (ent_rd.fill < SLOT_W'(WINDOW)) ?
                            ent_rd.fill + 1'b1 : ent_rd.fill;
        e_nxt             = e_r + 1'b1;
        state_nxt         = (e_r + 1'b1 == n_r) ? S_FINRD : S_E_RD;
      end
      // compute: sum ring, weight, divide by fill unless zero, write score, add to load
      S_C_RD: begin
        ent_rd_addr = e_idx;
        state_nxt   = S_C_LD;
      end
      S_C_LD: begin
        ent_nxt      = ent_rd;
        sum_nxt      = '0;
        k_nxt        = SLOT_W'(1);
        ring_rd_addr = ring_base;
        state_nxt    = (ent_rd.fill == '0) ? S_C_MUL : S_C_SUM;
      end
      S_C_SUM: begin
        sum_nxt = sum_r + SUM_W'(ring_q);
        if (k_r == ent_r.fill) begin
          state_nxt = S_C_MUL;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_C_MUL: begin
        p1_nxt    = P1_W'(ALPHA_ONE - a_r) * P1_W'(sum_r);
        p2_nxt    = P2_W'(a_r) * P2_W'(ent_r.count);
        state_nxt = S_C_NUM;
      end
      S_C_NUM: begin
        if (ent_r.fill == '0) begin
          score_nxt = p2_r[CNT_W+7:8];
          state_nxt = S_C_WR;
        end else begin
          div_start = 1'b1;
          state_nxt = S_C_DIV;
        end
      end
      S_C_DIV: begin
        if (div_done) begin
          score_nxt = div_quo;
          state_nxt = S_C_WR;
        end
      end
      S_C_WR: begin
        ent_wr_en         = 1'b1;
        ent_wr_data       = ent_r;
        ent_wr_data.score = score_r;
        load_nxt          = load_r + LOAD_W'(score_r);
        e_nxt             = e_r + 1'b1;
        state_nxt         = (e_r + 1'b1 == n_r) ? S_FINRD : S_C_RD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ----- tb/sv/windowed_access_load_tracker_tb.sv -----
// Testbench for the windowed access load tracker: directed table, then random
// words over several register settings; replies checked vs a predictor or table.
// Depends on lwat_pkg and windowed_access_load_tracker.
module windowed_access_load_tracker_tb;
  import lwat_pkg::*;

  localparam int NUM_ENT  = 64;
  localparam int RING_LEN = 12;

  // Opcodes 5 to 7 are unused by the block and behave as a read.
  localparam opcode_t OP_SPARE5 = 3'd5;
  localparam opcode_t OP_SPARE6 = 3'd6;
  localparam opcode_t OP_SPARE7 = 3'd7;

  typedef struct packed {
    logic [31:0] score;
    logic [37:0] load;
    logic        bad;
  } reply_t;

  typedef struct packed {
    opcode_t    op;
    logic [5:0] idx;
    bit         typed;
    reply_t     rsp;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;    // opcode[2:0], entry_index[8:3]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;        // entry_score[31:0], load_level[69:32], status[70]
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [8:0]  cfg_wdata = '0;

  windowed_access_load_tracker u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow copy of the tracker state.
  logic [31:0] access_cnt [NUM_ENT];
  logic [31:0] ring_val   [NUM_ENT][RING_LEN];
  int unsigned ring_fill  [NUM_ENT];
  int unsigned ring_slot  [NUM_ENT];
  logic [31:0] entry_score[NUM_ENT];
  logic [37:0] load_sum;
  logic [6:0]  active_cfg;
  logic [8:0]  alpha_cfg;

  reply_t      pending_replies[$];
  int          err_count = 0;
  int          burst_left = 0;

  // Blend of history mean and current count, truncated.
  function automatic logic [31:0] blended_score(input int e, input logic [8:0] a);
    logic [63:0] sum;
    logic [63:0] num;
    sum = '0;
    for (int k = 0; k < ring_fill[e]; k++) begin
      sum += ring_val[e][(ring_slot[e] + 2 * RING_LEN - 1 - k) % RING_LEN];
    end
    if (ring_fill[e] == 0) return 32'((64'(a) * access_cnt[e]) >> 8);
    num = 64'(256 - a) * sum + 64'(a) * access_cnt[e] * ring_fill[e];
    return 32'(num / (64'd256 * ring_fill[e]));
  endfunction

  // Apply one word to the shadow state and return the reply it should cause.
  function automatic reply_t tracker_predict(input opcode_t op, input logic [5:0] idx);
    int          n;
    logic [8:0]  a;
    bit          ok;
    reply_t      r;
    n  = (active_cfg > NUM_ENT) ? NUM_ENT : active_cfg;
    a  = (alpha_cfg > ALPHA_ONE) ? ALPHA_ONE : alpha_cfg;
    ok = idx < n;
    case (op)
      OP_COUNT: if (ok) access_cnt[idx] = access_cnt[idx] + 32'd1;
      OP_END: begin
        for (int e = 0; e < n; e++) begin
          ring_val[e][ring_slot[e]] = access_cnt[e];
          ring_slot[e] = (ring_slot[e] + 1) % RING_LEN;
          if (ring_fill[e] < RING_LEN) ring_fill[e]++;
          access_cnt[e] = '0;
        end
      end
      OP_CLEAR: begin
        if (ok) begin
          access_cnt[idx]  = '0;
          entry_score[idx] = '0;
          ring_fill[idx]   = 0;
          ring_slot[idx]   = 0;
        end
      end
      OP_COMPUTE: begin
        load_sum = '0;
        for (int e = 0; e < n; e++) begin
          entry_score[e] = blended_score(e, a);
          load_sum = load_sum + 38'(entry_score[e]);
        end
      end
      default: ;
    endcase
    r.score = ok ? entry_score[idx] : '0;
    r.load  = load_sum;
    r.bad   = !ok;
    return r;
  endfunction

  // Present one word, hold it until taken, queue its reply.
  task automatic send_word(input opcode_t op, input logic [5:0] idx,
                           input bit typed, input reply_t typed_rsp);
    reply_t p;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 40 : 6)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, idx, op};
    // Sample at the falling edge: stable values for the coming rising edge.
    do @(negedge clk); while (!in_tready);
    p = tracker_predict(op, idx);
    pending_replies.push_back(typed ? typed_rsp : p);
    @(posedge clk);
    burst_left--;
  endtask

  // Drain all replies, then let the block settle before a register write.
  task automatic drain_replies;
    @(posedge clk);
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_replies.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic index, input logic [8:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (index == CFG_ENTRIES) active_cfg = value[6:0];
    else alpha_cfg = value;
  endtask

  function automatic opcode_t pick_op;
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return OP_COUNT;
    if (r < 65) return OP_END;
    if (r < 70) return OP_COMPUTE;
    if (r < 76) return OP_CLEAR;
    if (r < 92) return OP_READ;
    return opcode_t'($urandom_range(5, 7));
  endfunction

  // Receiver: stall pattern redrawn at random among three modes.
  int unsigned rx_cycle = 0;
  int unsigned rx_mode  = 0;
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 256 == 0) rx_mode <= $urandom_range(0, 2);
    case (rx_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      default: out_tready <= (rx_cycle % 4 == 0);
    endcase
  end

  // Check each reply taken at the coming rising edge against the oldest expectation.
  always @(negedge clk) begin
    reply_t want;
    reply_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.score = out_tdata[31:0];
      got.load  = out_tdata[69:32];
      got.bad   = out_tdata[70];
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected word score=%h load=%h status=%b",
                 $time, got.score, got.load, got.bad);
        err_count++;
      end else begin
        want = pending_replies.pop_front();
        if (got.score !== want.score) begin
          $display("%0t: entry_score expected %h got %h", $time, want.score, got.score);
          err_count++;
        end
        if (got.load !== want.load) begin
          $display("%0t: load_level expected %h got %h", $time, want.load, got.load);
          err_count++;
        end
        if (got.bad !== want.bad) begin
          $display("%0t: status expected %b got %b", $time, want.bad, got.bad);
          err_count++;
        end
      end
    end
  end

  stim_row_t directed_rows[] = '{
    '{OP_READ,    6'd0,  1'b1, '{32'd0, 38'd0, 1'b0}},  // everything zero after reset
    '{OP_READ,    6'd63, 1'b1, '{32'd0, 38'd0, 1'b0}},
    '{OP_COMPUTE, 6'd0,  1'b1, '{32'd0, 38'd0, 1'b0}},  // compute over empty table
    '{OP_SPARE7,  6'd5,  1'b1, '{32'd0, 38'd0, 1'b0}},
    '{OP_COUNT,   6'd0,  1'b0, '0},
    '{OP_COUNT,   6'd0,  1'b0, '0},
    '{OP_COUNT,   6'd63, 1'b0, '0},
    '{OP_COMPUTE, 6'd63, 1'b0, '0},                     // empty rings: alpha * count only
    '{OP_READ,    6'd0,  1'b0, '0},
    '{OP_END,     6'd9,  1'b0, '0},                     // index ignored by end interval
    '{OP_COUNT,   6'd0,  1'b0, '0},
    '{OP_COMPUTE, 6'd42, 1'b0, '0},
    '{OP_SPARE5,  6'd0,  1'b0, '0},
    '{OP_SPARE6,  6'd63, 1'b0, '0},
    '{OP_CLEAR,   6'd0,  1'b0, '0},                     // clear keeps the load total
    '{OP_READ,    6'd0,  1'b0, '0},
    '{OP_END,     6'd0,  1'b0, '0},
    '{OP_COMPUTE, 6'd0,  1'b0, '0},
    '{OP_CLEAR,   6'd63, 1'b0, '0},
    '{OP_READ,    6'd63, 1'b0, '0},
    '{OP_READ,    6'd32, 1'b0, '0}
  };

  // Register settings per random phase: table size, then alpha.
  logic [8:0] phase_entries[] = '{9'd1, 9'd127, 9'd0, 9'd37, 9'd64, 9'd64};
  logic [8:0] phase_alpha[]   = '{9'd0, 9'd511, 9'd256, 9'd77, 9'd255, 9'd128};

  initial begin
    int n;
    logic [5:0] idx;
    for (int e = 0; e < NUM_ENT; e++) begin
      access_cnt[e]  = '0;
      ring_fill[e]   = 0;
      ring_slot[e]   = 0;
      entry_score[e] = '0;
      for (int k = 0; k < RING_LEN; k++) ring_val[e][k] = '0;
    end
    load_sum   = '0;
    active_cfg = 7'd64;
    alpha_cfg  = 9'd128;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table under reset settings.
    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].op, directed_rows[i].idx,
                directed_rows[i].typed, directed_rows[i].rsp);
    end

    // Random phases; most words hit active entries so rings fill up.
    foreach (phase_entries[p]) begin
      drain_replies();
      write_reg(CFG_ENTRIES, phase_entries[p]);
      write_reg(CFG_ALPHA, phase_alpha[p]);
      n = (active_cfg > NUM_ENT) ? NUM_ENT : active_cfg;
      for (int i = 0; i < 215; i++) begin
        if (n > 0 && $urandom_range(0, 9) < 8) idx = 6'($urandom_range(0, n - 1));
        else idx = 6'($urandom_range(0, 63));
        send_word(pick_op(), idx, 1'b0, '0);
      end
    end
    in_tvalid <= 1'b0;

    // Wait for the tail, bounded.
    for (int c = 0; c < 500000 && pending_replies.size() != 0; c++) @(negedge clk);
    if (pending_replies.size() != 0) begin
      $display("%0t: %0d replies never arrived", $time, pending_replies.size());
      err_count++;
    end
    repeat (100) @(posedge clk);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #400000000;
    $display("simulation failed");
    $finish;
  end

endmodule
